[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the expected count block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define STEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define STEC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define STEC_ASSERT(lbl, prop, msg)
`define STEC_NEVER(lbl, cond, msg)
`endif
`endif

[src/stec_pkg.sv]
// ----------------------------------------------------------------------------
// stec_pkg
// types, codes and constants of the expected count block
// ----------------------------------------------------------------------------
`default_nettype none
package stec_pkg;
	localparam int MAX_INTERVALS = 64;
	localparam int MAX_LOCATIONS = 256;
	localparam int FRACTION_BITS = 16;

	localparam int COUNT_W = 24;
	localparam int TOTAL_W = 31;
	localparam int ROWSUM_W = 32;
	localparam int MEAS_W = 32 + FRACTION_BITS;
	localparam int RATIO_W = ROWSUM_W + FRACTION_BITS;
	localparam int CFG_W = 16;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	localparam logic [1:0] REG_INTERVAL_COUNT = 2'd0;
	localparam logic [1:0] REG_LOCATION_COUNT = 2'd1;
	localparam logic [1:0] REG_MATCH_TOLERANCE = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [23:0] case_count;
		logic [30:0] category_total;
		logic [5:0] read_interval;
		logic [7:0] read_location;
	} in_item_t;

	typedef struct packed {
		logic [47:0] measure_value;
		logic [30:0] total_cases;
		logic [47:0] total_measure;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_SUM,
		ST_CHECK,
		ST_READ,
		ST_EMIT
	} state_t;

	// register value to effective count: zero acts as one, clipped at the maximum
	function automatic logic [31:0] eff_count(input logic [31:0] value, input int max_val);
		logic [31:0] r;
		if (value == 32'd0) begin
			r = 32'd1;
		end else if (value > 32'(max_val)) begin
			r = 32'(max_val);
		end else begin
			r = value;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[src/stec_ram.sv]
// ----------------------------------------------------------------------------
// stec_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none
module stec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[src/space_time_expected_counts.sv]
// ----------------------------------------------------------------------------
// space_time_expected_counts
// expected count builder for a space-time permutation scan, fixed point
// ----------------------------------------------------------------------------
// Case counts stream in per category, row by row. The last element of a row
// of a category with a nonzero total starts a ratio divide (one quotient bit
// per cycle) and then a pipelined pass over the measure memory, one location
// per cycle on its one read port and one write port; other loads are taken without
// a stall. A finish item sums measure row 0. After reset the block clears the
// measure memory, one entry per cycle, MAX_INTERVALS*MAX_LOCATIONS entries
// (16384 by default), and takes no item meanwhile. Results sit in an output
// register; loads are taken while it waits.
`default_nettype none
`include "assert_macros.svh"
module space_time_expected_counts #(
	parameter int MAX_INTERVALS = stec_pkg::MAX_INTERVALS,
	parameter int MAX_LOCATIONS = stec_pkg::MAX_LOCATIONS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire stec_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output stec_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [stec_pkg::CFG_W-1:0] cfg_data
);
	localparam int DEPTH = MAX_INTERVALS * MAX_LOCATIONS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int LW = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
	localparam int LCW = $clog2(MAX_LOCATIONS + 1);
	localparam int FB = stec_pkg::FRACTION_BITS;
	localparam int CW = stec_pkg::COUNT_W;
	localparam int TW = stec_pkg::TOTAL_W;
	localparam int SW = stec_pkg::ROWSUM_W;
	localparam int MW = stec_pkg::MEAS_W;
	localparam int RW = stec_pkg::RATIO_W;
	localparam int RL = RW / 2;
	localparam int RH = RW - RL;
	localparam int PW = CW + RW;
	localparam int DCW = $clog2(RW);

	stec_pkg::state_t state_q, state_n;

	// configuration registers
	logic [6:0] ivl_cfg_q;
	logic [8:0] loc_cfg_q;
	logic [15:0] tol_q;
	logic [31:0] ivls, locs;

	// stream position and sums
	logic [IW-1:0] ipos_q;
	logic [LW-1:0] lpos_q;
	logic [SW-1:0] rsum_q;
	logic [TW-1:0] held_q;
	logic [TW-1:0] csum_q;
	logic ovf_q;

	// divider
	logic [RW-1:0] quo_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] div_d_q;
	logic [DCW-1:0] div_cnt_q;
	logic [TW:0] rem_sh;
	logic rem_ge;

	// pass pipeline
	logic [IW-1:0] pass_ivl_q;
	logic [LCW-1:0] j_q;
	logic issuing;
	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] a_s1, a_s2, a_s3;
	logic [2*RL-1:0] plo_s2;
	logic [CW+RH-1:0] phi_s2;
	logic [MW-1:0] m_s2, m_s3, prod_s3;
	logic [PW-1:0] prod_full;
	logic [MW:0] msum;

	// finish and read
	logic [MW-1:0] acc_q;
	logic [MW:0] acc_sum;
	logic [MW-1:0] cq, diff;
	logic rd_ok_q;
	logic [AW-1:0] clr_q;
	stec_pkg::out_item_t res_q, out_q;
	logic out_valid_q;

	// memory ports
	logic fr_we, fr_re;
	logic [LW-1:0] fr_waddr, fr_raddr;
	logic [CW-1:0] fr_rdata;
	logic meas_we, meas_re;
	logic [AW-1:0] meas_waddr, meas_raddr;
	logic [MW-1:0] meas_wdata, meas_rdata;

	// load decode
	logic acc_in, ld, fin, rdm, emit_ok;
	logic [31:0] ip0, lp0, lpe;
	logic wrap;
	logic [SW-1:0] rs0;
	logic [SW:0] rs_add;
	logic [SW-1:0] rs_n;
	logic [TW-1:0] held_n;
	logic [TW:0] cs_add;
	logic row_end;
	logic [31:0] rd_addr;
	logic rd_in_range;

	assign ivls = stec_pkg::eff_count(32'(ivl_cfg_q), MAX_INTERVALS);
	assign locs = stec_pkg::eff_count(32'(loc_cfg_q), MAX_LOCATIONS);

	assign in_stall = (state_q != stec_pkg::ST_IDLE);
	assign acc_in = in_valid && !in_stall;
	assign ld = acc_in && (in_data.mode == stec_pkg::MODE_LOAD);
	assign fin = acc_in && (in_data.mode == stec_pkg::MODE_FINISH);
	assign rdm = acc_in && (in_data.mode == stec_pkg::MODE_READ);
	assign emit_ok = !out_valid_q || !out_stall;

	// position clean-up for counts changed mid-stream
	always_comb begin
		wrap = 32'(ipos_q) >= ivls;
		ip0 = wrap ? 32'd0 : 32'(ipos_q);
		lp0 = wrap ? 32'd0 : 32'(lpos_q);
		rs0 = wrap ? '0 : rsum_q;
		lpe = (lp0 >= locs) ? (locs - 32'd1) : lp0;
		held_n = (ip0 == 32'd0 && lpe == 32'd0) ? in_data.category_total : held_q;
		rs_add = {1'b0, rs0} + (SW+1)'(in_data.case_count);
		rs_n = rs_add[SW] ? '1 : rs_add[SW-1:0];
		cs_add = {1'b0, csum_q} + (TW+1)'(in_data.case_count);
		row_end = (lpe + 32'd1) >= locs;
		rd_in_range = (32'(in_data.read_interval) < 32'(MAX_INTERVALS))
			&& (32'(in_data.read_location) < 32'(MAX_LOCATIONS));
		rd_addr = 32'(in_data.read_interval) * 32'(MAX_LOCATIONS)
			+ 32'(in_data.read_location);
	end

	// divider step
	assign rem_sh = {rem_q, quo_q[RW-1]};
	assign rem_ge = rem_sh >= {1'b0, div_d_q};

	assign issuing = 32'(j_q) < locs;

	// product assembly and saturation
	assign prod_full = (PW'(phi_s2) << RL) + PW'(plo_s2);
	assign msum = {1'b0, m_s3} + {1'b0, prod_s3};
	assign acc_sum = {1'b0, acc_q} + {1'b0, meas_rdata};
	assign cq = MW'({csum_q, {FB{1'b0}}});
	assign diff = (cq > acc_q) ? (cq - acc_q) : (acc_q - cq);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			stec_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_n = stec_pkg::ST_IDLE;
			end
			stec_pkg::ST_IDLE: begin
				if (ld && row_end && held_n != '0) state_n = stec_pkg::ST_DIV;
				else if (fin) state_n = stec_pkg::ST_SUM;
				else if (rdm) state_n = stec_pkg::ST_READ;
			end
			stec_pkg::ST_DIV: begin
				if (div_cnt_q == '0) state_n = stec_pkg::ST_UPD;
			end
			stec_pkg::ST_UPD: begin
				if (!issuing && !v_s1 && !v_s2 && !v_s3) state_n = stec_pkg::ST_IDLE;
			end
			stec_pkg::ST_SUM: begin
				if (!issuing && !v_s1) state_n = stec_pkg::ST_CHECK;
			end
			stec_pkg::ST_CHECK: state_n = stec_pkg::ST_EMIT;
			stec_pkg::ST_READ: state_n = stec_pkg::ST_EMIT;
			stec_pkg::ST_EMIT: begin
				if (emit_ok) state_n = stec_pkg::ST_IDLE;
			end
			default: state_n = stec_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		fr_we = ld && (ip0 == 32'd0);
		fr_waddr = LW'(lpe);
		fr_re = 1'b0;
		fr_raddr = LW'(j_q);
		meas_we = v_s3;
		meas_waddr = a_s3;
		meas_wdata = msum[MW] ? '1 : msum[MW-1:0];
		meas_re = 1'b0;
		meas_raddr = AW'(j_q);
		unique case (state_q)
			stec_pkg::ST_CLEAR: begin
				meas_we = 1'b1;
				meas_waddr = clr_q;
				meas_wdata = '0;
			end
			stec_pkg::ST_IDLE: begin
				meas_re = rdm && rd_in_range;
				meas_raddr = AW'(rd_addr);
			end
			stec_pkg::ST_UPD: begin
				fr_re = issuing;
				meas_re = issuing;
				meas_raddr = AW'(pass_ivl_q) * AW'(MAX_LOCATIONS) + AW'(j_q);
			end
			stec_pkg::ST_SUM: begin
				meas_re = issuing;
			end
			default: begin
				meas_re = 1'b0;
			end
		endcase
	end

	stec_ram #(.WIDTH(CW), .DEPTH(MAX_LOCATIONS)) u_first_row (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(in_data.case_count),
		.re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
	);

	stec_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_measure (
		.clk(clk), .we(meas_we), .waddr(meas_waddr), .wdata(meas_wdata),
		.re(meas_re), .raddr(meas_raddr), .rdata(meas_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_cfg_q <= 7'd1;
			loc_cfg_q <= 9'd1;
			tol_q <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stec_pkg::REG_INTERVAL_COUNT: ivl_cfg_q <= cfg_data[6:0];
				stec_pkg::REG_LOCATION_COUNT: loc_cfg_q <= cfg_data[8:0];
				stec_pkg::REG_MATCH_TOLERANCE: tol_q <= cfg_data[15:0];
				default: tol_q <= tol_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stec_pkg::ST_CLEAR;
			clr_q <= '0;
			ipos_q <= '0;
			lpos_q <= '0;
			rsum_q <= '0;
			held_q <= '0;
			csum_q <= '0;
			ovf_q <= 1'b0;
			j_q <= '0;
			div_cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == stec_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			// load transfer
			if (ld) begin
				held_q <= held_n;
				if (ip0 == 32'd0) begin
					if (cs_add[TW]) begin
						csum_q <= '1;
						ovf_q <= 1'b1;
					end else begin
						csum_q <= cs_add[TW-1:0];
					end
				end
				if (row_end) begin
					rsum_q <= '0;
					lpos_q <= '0;
					ipos_q <= ((ip0 + 32'd1) >= ivls) ? '0 : IW'(ip0 + 32'd1);
				end else begin
					rsum_q <= rs_n;
					lpos_q <= LW'(lpe + 32'd1);
					ipos_q <= IW'(ip0);
				end
			end
			if (state_n == stec_pkg::ST_DIV && state_q == stec_pkg::ST_IDLE) begin
				div_cnt_q <= DCW'(RW - 1);
			end else if (state_q == stec_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			// pass issue counter
			if (state_q == stec_pkg::ST_IDLE || state_q == stec_pkg::ST_DIV) begin
				j_q <= '0;
			end else if ((state_q == stec_pkg::ST_UPD || state_q == stec_pkg::ST_SUM)
					&& issuing) begin
				j_q <= j_q + LCW'(1);
			end
			v_s1 <= (state_q == stec_pkg::ST_UPD || state_q == stec_pkg::ST_SUM) && issuing;
			v_s2 <= v_s1 && (state_q == stec_pkg::ST_UPD);
			v_s3 <= v_s2;
			// output register
			if (state_q == stec_pkg::ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ld && row_end) begin
			quo_q <= {rs_n, {FB{1'b0}}};
			rem_q <= '0;
			div_d_q <= held_n;
			pass_ivl_q <= IW'(ip0);
		end else if (state_q == stec_pkg::ST_DIV) begin
			quo_q <= {quo_q[RW-2:0], rem_ge};
			rem_q <= rem_ge ? TW'(rem_sh - {1'b0, div_d_q}) : rem_sh[TW-1:0];
		end
		a_s1 <= meas_raddr;
		a_s2 <= a_s1;
		a_s3 <= a_s2;
		plo_s2 <= fr_rdata * quo_q[RL-1:0];
		phi_s2 <= fr_rdata * quo_q[RW-1:RL];
		m_s2 <= meas_rdata;
		m_s3 <= m_s2;
		prod_s3 <= (prod_full[PW-1:MW] != '0) ? '1 : prod_full[MW-1:0];
		if (fin) begin
			acc_q <= '0;
		end else if (state_q == stec_pkg::ST_SUM && v_s1) begin
			acc_q <= acc_sum[MW] ? '1 : acc_sum[MW-1:0];
		end
		if (rdm) rd_ok_q <= rd_in_range;
		if (state_q == stec_pkg::ST_READ) begin
			res_q.measure_value <= rd_ok_q ? meas_rdata : '0;
			res_q.total_cases <= '0;
			res_q.total_measure <= '0;
			res_q.status <= stec_pkg::STATUS_OK;
		end else if (state_q == stec_pkg::ST_CHECK) begin
			res_q.measure_value <= '0;
			res_q.total_cases <= csum_q;
			res_q.total_measure <= acc_q;
			if (ovf_q) res_q.status <= stec_pkg::STATUS_OVERFLOW;
			else if (diff > MW'(tol_q)) res_q.status <= stec_pkg::STATUS_MISMATCH;
			else res_q.status <= stec_pkg::STATUS_OK;
		end
		if (state_q == stec_pkg::ST_EMIT && emit_ok) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// pipeline only runs during a pass
	`STEC_ASSERT(a_pipe_in_pass, (v_s1 || v_s2 || v_s3) |-> (state_q == stec_pkg::ST_UPD || state_q == stec_pkg::ST_SUM), "pass pipeline active outside a pass")
	// divider hands over to the update pass
	`STEC_ASSERT(a_div_to_upd, (state_q == stec_pkg::ST_DIV && div_cnt_q == '0) |=> (state_q == stec_pkg::ST_UPD), "divide did not start update pass")
	// no measure write while idle
	`STEC_NEVER(a_no_idle_write, meas_we && state_q == stec_pkg::ST_IDLE, "measure write while idle")
endmodule
`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the space-time expected count builder
// ----------------------------------------------------------------------------
// A directed table runs first: empty totals, zero and saturated category
// totals, the largest counts and read indexes, and the unused mode. It is
// followed by random phases of whole categories under several register
// settings, with out-of-range counts, a row cut short by shrinking the counts
// mid-category, a long hold-off on the output side and case-sum saturation.
// Every result is compared field by field with a table entry or an in-bench prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import stec_pkg::*;

	localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned M31 = 64'h7FFF_FFFF;
	localparam longint unsigned M32 = 64'hFFFF_FFFF;
	localparam int SETTLE_CYCLES = 400;
	localparam int QUIET_LIMIT = 60000;
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_INTERVAL_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;

	space_time_expected_counts i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// predicted block state
	logic [6:0] pr_intervals = 7'd1;
	logic [8:0] pr_locations = 9'd1;
	logic [15:0] pr_tolerance = 16'd7;
	logic [23:0] pr_row0 [MAX_LOCATIONS];
	longint unsigned pr_measure [MAX_INTERVALS*MAX_LOCATIONS];
	int pr_ipos = 0;
	int pr_lpos = 0;
	longint unsigned pr_row_sum = 0;
	longint unsigned pr_cat_total = 0;
	longint unsigned pr_case_sum = 0;
	bit pr_overflow = 1'b0;

	out_item_t pending_results [$];
	int errors = 0;
	int idle_mode = IDLE_NONE;
	int hold_left = 0;
	int quiet_cycles = 0;

	initial begin
		for (int k = 0; k < MAX_INTERVALS*MAX_LOCATIONS; k++) pr_measure[k] = 0;
		for (int k = 0; k < MAX_LOCATIONS; k++) pr_row0[k] = '0;
	end

	function automatic int eff_of(int v, int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	// one load: row bookkeeping and measure update at row end
	function automatic void load_case(logic [23:0] cnt, logic [30:0] tot);
		int ivls;
		int locs;
		longint unsigned ratio;
		longint unsigned s;
		longint unsigned prod;
		longint unsigned sum;
		ivls = eff_of(int'(pr_intervals), MAX_INTERVALS);
		locs = eff_of(int'(pr_locations), MAX_LOCATIONS);
		if (pr_ipos >= ivls) begin
			pr_ipos = 0;
			pr_lpos = 0;
			pr_row_sum = 0;
		end
		if (pr_lpos >= locs) pr_lpos = locs - 1;
		if (pr_ipos == 0 && pr_lpos == 0) pr_cat_total = 64'(tot);
		pr_row_sum += 64'(cnt);
		if (pr_row_sum > M32) pr_row_sum = M32;
		if (pr_ipos == 0) begin
			pr_row0[pr_lpos] = cnt;
			pr_case_sum += 64'(cnt);
			if (pr_case_sum > M31) begin
				pr_case_sum = M31;
				pr_overflow = 1'b1;
			end
		end
		if (pr_lpos + 1 >= locs) begin
			if (pr_cat_total != 0) begin
				ratio = (pr_row_sum << FRACTION_BITS) / pr_cat_total;
				for (int j = 0; j < locs; j++) begin
					s = 64'(pr_row0[j]);
					if (ratio != 0 && s > M48 / ratio) prod = M48;
					else prod = ratio * s;
					sum = pr_measure[pr_ipos*MAX_LOCATIONS + j] + prod;
					pr_measure[pr_ipos*MAX_LOCATIONS + j] = (sum > M48) ? M48 : sum;
				end
			end
			pr_row_sum = 0;
			pr_lpos = 0;
			pr_ipos++;
			if (pr_ipos >= ivls) pr_ipos = 0;
		end else begin
			pr_lpos++;
		end
	endfunction

	// advance the prediction by one item; returns 1 when a result is due
	function automatic bit predict_item(in_item_t it, output out_item_t res);
		longint unsigned tm;
		longint unsigned cq;
		longint unsigned diff;
		int locs;
		res = '0;
		case (it.mode)
			MODE_LOAD: begin
				load_case(it.case_count, it.category_total);
				return 1'b0;
			end
			MODE_FINISH: begin
				locs = eff_of(int'(pr_locations), MAX_LOCATIONS);
				tm = 0;
				for (int j = 0; j < locs; j++) begin
					tm += pr_measure[j];
					if (tm > M48) tm = M48;
				end
				cq = pr_case_sum << FRACTION_BITS;
				diff = (cq > tm) ? cq - tm : tm - cq;
				res.total_cases = pr_case_sum[30:0];
				res.total_measure = tm[47:0];
				if (pr_overflow) res.status = STATUS_OVERFLOW;
				else if (diff > pr_tolerance) res.status = STATUS_MISMATCH;
				else res.status = STATUS_OK;
				return 1'b1;
			end
			MODE_READ: begin
				res.measure_value = 48'(
					pr_measure[int'(it.read_interval)*MAX_LOCATIONS + int'(it.read_location)]);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result checking and output stall
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(out_data.measure_value), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.measure_value !== want.measure_value)
					report_mismatch("measure_value", 64'(out_data.measure_value),
						64'(want.measure_value));
				if (out_data.total_cases !== want.total_cases)
					report_mismatch("total_cases", 64'(out_data.total_cases),
						64'(want.total_cases));
				if (out_data.total_measure !== want.total_measure)
					report_mismatch("total_measure", 64'(out_data.total_measure),
						64'(want.total_measure));
				if (out_data.status !== want.status)
					report_mismatch("status", 64'(out_data.status), 64'(want.status));
			end
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (idle_mode == IDLE_RECV) begin
			out_stall <= ($urandom_range(99) < 64);
		end else if (idle_mode == IDLE_BOTH) begin
			out_stall <= ($urandom_range(99) < 30);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one input transfer, with random sender gaps
	task automatic send_item(in_item_t it);
		out_item_t res;
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 30 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_item(it, res)) pending_results.push_back(res);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INTERVAL_COUNT: pr_intervals = 7'(value);
			REG_LOCATION_COUNT: pr_locations = 9'(value);
			default: pr_tolerance = 16'(value);
		endcase
	endtask

	function automatic in_item_t random_load(bit big);
		in_item_t it;
		int r;
		it = '0;
		it.mode = MODE_LOAD;
		r = $urandom_range(99);
		if (big) it.case_count = 24'hFF_FFFF;
		else if (r < 2) it.case_count = 24'($urandom);
		else if (r < 7) it.case_count = '0;
		else if (r < 60) it.case_count = 24'($urandom_range(50));
		else it.case_count = 24'($urandom_range(5000));
		r = $urandom_range(99);
		if (r < 5) it.category_total = '0;
		else if (r < 10) it.category_total = 31'($urandom);
		else it.category_total = 31'($urandom_range(100000, 1));
		it.read_interval = 6'($urandom);
		it.read_location = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t random_item(bit big);
		in_item_t it;
		int r;
		it = random_load(big);
		r = $urandom_range(99);
		if (r >= 98) begin
			it.mode = MODE_UNUSED;
		end else if (r >= 90) begin
			it.mode = MODE_FINISH;
		end else if (r >= 78) begin
			it.mode = MODE_READ;
			if ($urandom_range(1)) begin
				it.read_interval = 6'($urandom_range(
					eff_of(int'(pr_intervals), MAX_INTERVALS) - 1));
				it.read_location = 8'($urandom_range(
					eff_of(int'(pr_locations), MAX_LOCATIONS) - 1));
			end
		end
		return it;
	endfunction

	// a phase of whole categories under one register setting, changed mid-phase when shrink is set
	task automatic run_phase(int ivl, int loc, int tol, int idle, int budget,
			bit big, bit shrink, bit hold);
		in_item_t it;
		int n;
		drain();
		write_reg(REG_INTERVAL_COUNT, ivl);
		write_reg(REG_LOCATION_COUNT, loc);
		write_reg(REG_MATCH_TOLERANCE, tol);
		idle_mode = idle;
		if (hold) hold_left = 400;
		n = 0;
		while (n < budget || pr_ipos != 0 || pr_lpos != 0) begin
			if (shrink && n == 13) begin
				// cut the counts mid-category; the block restarts an out-of-range row and clips the location
				drain();
				write_reg(REG_INTERVAL_COUNT, 2);
				write_reg(REG_LOCATION_COUNT, 3);
			end
			if (n >= budget || big) it = random_load(big);
			else it = random_item(1'b0);
			send_item(it);
			n++;
		end
		it = '0;
		it.mode = MODE_FINISH;
		send_item(it);
	endtask

	typedef struct {
		in_item_t it;
		bit typed;
		out_item_t want;
	} table_row_t;

	function automatic table_row_t mk_row(logic [1:0] mode, logic [23:0] cnt, logic [30:0] tot,
			logic [5:0] ri, logic [7:0] rl, bit typed, logic [47:0] mv, logic [30:0] tc,
			logic [47:0] tm, logic [1:0] st);
		table_row_t r;
		r.it = '{mode: mode, case_count: cnt, category_total: tot,
			read_interval: ri, read_location: rl};
		r.typed = typed;
		r.want = '{measure_value: mv, total_cases: tc, total_measure: tm, status: st};
		return r;
	endfunction

	// stimulus
	initial begin
		table_row_t rows [$];
		// empty state, extremes, exact match, zero totals, saturation, unused mode
		rows.push_back(mk_row(MODE_FINISH, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_READ, 0, 0, 6'd63, 8'd255, 1, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_LOAD, 24'd7, 31'd7, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_FINISH, 0, 0, 0, 0, 1, 0, 31'd7, 48'd458752, STATUS_OK));
		rows.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 1, 48'd458752, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_LOAD, 24'd0, 31'd0, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_LOAD, 24'd5, 31'd0, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_FINISH, 0, 0, 0, 0, 1, 0, 31'd12, 48'd458752,
			STATUS_MISMATCH));
		rows.push_back(mk_row(MODE_UNUSED, 24'hFF_FFFF, 31'h7FFF_FFFF, 6'd63, 8'd255, 0,
			0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_LOAD, 24'hFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0,
			STATUS_OK));
		rows.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_LOAD, 24'hFF_FFFF, 31'd1, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_OK));
		rows.push_back(mk_row(MODE_READ, 0, 0, 6'd1, 8'd128, 0, 0, 0, 0, STATUS_OK));

		@(posedge clk);
		while (!arst_n) @(posedge clk);
		foreach (rows[k]) begin
			if (rows[k].typed) begin
				send_item(rows[k].it);
				void'(pending_results.pop_back());
				pending_results.push_back(rows[k].want);
			end else begin
				send_item(rows[k].it);
			end
		end

		// random phases: counts, tolerance, idling
		run_phase(4, 8, 100, IDLE_NONE, 150, 0, 0, 0);
		run_phase(0, 300, 0, IDLE_SEND, 50, 0, 0, 0);
		run_phase(64, 2, 65535, IDLE_RECV, 100, 0, 0, 0);
		run_phase(0, 0, 7, IDLE_BOTH, 60, 0, 0, 0);
		run_phase(100, 1, 30, IDLE_NONE, 80, 0, 0, 0);
		run_phase(4, 8, 200, IDLE_BOTH, 120, 0, 1, 0);
		run_phase(3, 5, 1000, IDLE_NONE, 120, 0, 0, 1);
		run_phase(3, 5, 1000, IDLE_BOTH, 100, 0, 0, 0);
		run_phase(1, 8, 65535, IDLE_RECV, 136, 1, 0, 0);
		run_phase(2, 4, 0, IDLE_SEND, 60, 0, 0, 0);

		// wait for the last results
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
+incdir+src
src/stec_pkg.sv
src/stec_ram.sv
src/space_time_expected_counts.sv
dv/tb_top.sv
